FILE: design/rsenc_pkg.sv
// Shared types, constants and GF(2^8) helpers for the Reed-Solomon encoder.
// Field polynomial x^8+x^4+x^3+x^2+1 (0x11d), primitive element 2.
// No dependencies; imported by rsenc_gen_builder and the encoder top level.
package rsenc_pkg;

    localparam int SYM_W        = 8;
    localparam int MAX_PARITY   = 32;
    localparam int PCNT_W       = $clog2(MAX_PARITY + 1);
    localparam int PARITY_RESET = 10;
    localparam logic [SYM_W:0] FIELD_POLY = 9'h11d;

    typedef logic [SYM_W-1:0]            sym_t;
    typedef sym_t [MAX_PARITY-1:0]       sym_vec_t;
    typedef logic [PCNT_W-1:0]           pcnt_t;

    // Request to rebuild the generator polynomial
    typedef struct packed {
        logic  start;
        pcnt_t count;
    } gen_ctl_t;

    // Multiply by alpha (x) modulo the field polynomial
    function automatic sym_t gf_xtime(input sym_t a);
        logic [SYM_W:0] t;
        t = {a, 1'b0};
        if (t[SYM_W]) begin
            t = t ^ FIELD_POLY;
        end
        return t[SYM_W-1:0];
    endfunction

    // Full GF(2^8) multiply, shift-and-add over the 8 bits of b
    function automatic sym_t gf_mul(input sym_t a, input sym_t b);
        sym_t x;
        sym_t acc;
        x   = a;
        acc = '0;
        for (int k = 0; k < SYM_W; k++) begin
            if (b[k]) begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        return acc;
    endfunction

endpackage

FILE: design/rsenc_gen_builder.sv
// Generator polynomial builder: multiplies (x+alpha^0)...(x+alpha^(p-1)) one factor
// per cycle, all coefficients updated in parallel. Depends on rsenc_pkg.
// Starts itself out of reset for the default parity count.
module rsenc_gen_builder (
    input  logic                aclk,
    input  logic                aresetn,
    input  rsenc_pkg::gen_ctl_t ctl,
    output logic                busy,
    output rsenc_pkg::sym_vec_t coeffs
);
    import rsenc_pkg::*;

    // coefficient k of the register holds g(k+1); leading g0 is always 1
    sym_vec_t g_reg, g_next;
    sym_t     root_reg;
    pcnt_t    step_reg;
    pcnt_t    count_reg;
    logic     busy_reg;

    // One factor (x + root) applied to every coefficient at once
    always_comb begin
        g_next[0] = g_reg[0] ^ root_reg;
        for (int k = 1; k < MAX_PARITY; k++) begin
            g_next[k] = g_reg[k] ^ gf_mul(root_reg, g_reg[k-1]);
        end
    end

    // Sequencer: clear on start, then count factors up to the parity count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_reg     <= '0;
            root_reg  <= sym_t'(1);
            step_reg  <= '0;
            count_reg <= pcnt_t'(PARITY_RESET);
            busy_reg  <= 1'b1;
        end else if (ctl.start) begin
            g_reg     <= '0;
            root_reg  <= sym_t'(1);
            step_reg  <= '0;
            count_reg <= ctl.count;
            busy_reg  <= 1'b1;
        end else if (busy_reg) begin
            g_reg    <= g_next;
            root_reg <= gf_xtime(root_reg);
            step_reg <= step_reg + pcnt_t'(1);
            if (step_reg == count_reg - pcnt_t'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy   = busy_reg;
    assign coeffs = g_reg;

endmodule

FILE: design/reed_solomon_systematic_encoder_core.sv
// Systematic RS(GF(2^8), 0x11d) encoder top level. Depends on rsenc_pkg, rsenc_gen_builder.
// A message byte is registered and appears on m_tdata in the cycle after its transaction.
// Throughput: one byte per cycle while m_tready is high; n message bytes give n + p bytes,
// the p parity bytes following the last message byte back to back, input held off meanwhile.
// Reset: synchronous, active low; count returns to 10 and the generator is rebuilt,
// as after each count write, with s_tready low until it is done.
module reed_solomon_systematic_encoder_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration: parity count
    input  logic                 cfg_wr_en,
    input  rsenc_pkg::pcnt_t     cfg_wr_data,
    // message input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_symbol
    input  logic                 s_tlast,   // end_of_message
    // codeword output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] out_symbol
    output logic [0:0]           m_tuser,   // [0] is_parity
    output logic                 m_tlast    // codeword_last
);
    import rsenc_pkg::*;

    pcnt_t    parity_count_reg;
    pcnt_t    parity_left_reg;
    sym_vec_t rem_reg, rem_next;
    sym_vec_t coeffs;
    gen_ctl_t gen_ctl;
    logic     gen_busy;

    logic     m_valid_reg;
    sym_t     m_data_reg;
    logic     m_user_reg;
    logic     m_last_reg;

    logic     cfg_ok;
    logic     out_free;
    logic     load_echo;
    logic     load_par;
    sym_t     fb;

    // Count write decode; out-of-range values are dropped
    assign cfg_ok = cfg_wr_en && (cfg_wr_data != '0) &&
                    (cfg_wr_data <= pcnt_t'(MAX_PARITY));
    assign gen_ctl.start = cfg_ok;
    assign gen_ctl.count = cfg_wr_data;

    rsenc_gen_builder u_gen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (gen_ctl),
        .busy    (gen_busy),
        .coeffs  (coeffs)
    );

    // Handshake: output register free, generator ready, no parity pending
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = out_free && !gen_busy && (parity_left_reg == '0);
    assign load_echo = s_tvalid && s_tready;
    assign load_par  = out_free && (parity_left_reg != '0);

    // Remainder update: LFSR division step, or shift out one parity byte
    assign fb = s_tdata ^ rem_reg[0];
    always_comb begin
        rem_next = rem_reg;
        if (load_echo) begin
            for (int j = 0; j < MAX_PARITY - 1; j++) begin
                rem_next[j] = rem_reg[j+1] ^ gf_mul(coeffs[j], fb);
            end
            rem_next[MAX_PARITY-1] = gf_mul(coeffs[MAX_PARITY-1], fb);
        end else if (load_par) begin
            for (int j = 0; j < MAX_PARITY - 1; j++) begin
                rem_next[j] = rem_reg[j+1];
            end
            rem_next[MAX_PARITY-1] = '0;
        end
    end

    // Control state: count, parity countdown, remainder
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_count_reg <= pcnt_t'(PARITY_RESET);
            parity_left_reg  <= '0;
            rem_reg          <= '0;
        end else if (cfg_ok) begin
            parity_count_reg <= cfg_wr_data;
            parity_left_reg  <= '0;
            rem_reg          <= '0;
        end else begin
            rem_reg <= rem_next;
            if (load_echo && s_tlast) begin
                parity_left_reg <= parity_count_reg;
            end else if (load_par) begin
                parity_left_reg <= parity_left_reg - pcnt_t'(1);
            end
        end
    end

    // Output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_echo || load_par) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload: echoed byte or next parity byte
    always_ff @(posedge aclk) begin
        if (load_echo) begin
            m_data_reg <= s_tdata;
            m_user_reg <= 1'b0;
            m_last_reg <= 1'b0;
        end else if (load_par) begin
            m_data_reg <= rem_reg[0];
            m_user_reg <= 1'b1;
            m_last_reg <= (parity_left_reg == pcnt_t'(1));
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;
    assign m_tlast    = m_last_reg;

    // No message byte taken while the generator is being rebuilt
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !gen_busy)
        else $error("transaction accepted during generator rebuild");

    // A last byte schedules exactly p parity bytes
    a_parity_sched: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast && !cfg_wr_en)
            |=> (parity_left_reg == $past(parity_count_reg)))
        else $error("parity countdown not loaded with parity count");

    // The final codeword byte is always a parity byte
    a_last_is_parity: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser[0])
        else $error("codeword end flagged on a message byte");

    // Remainder is fully drained once the last parity byte is loaded
    a_rem_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_par && parity_left_reg == pcnt_t'(1)) |=> (rem_reg == '0))
        else $error("remainder not clear after parity");

endmodule

FILE: bench/reed_solomon_systematic_encoder_core_test.sv
// Self-checking bench for reed_solomon_systematic_encoder_core: a queue-fed stream driver,
// a GF(2^8) parity predictor and a monitor that checks every codeword byte in order.
// Depends on rsenc_pkg and the encoder RTL; needs no files or arguments.
module reed_solomon_systematic_encoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rsenc_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        sym_t data;
        logic last;
    } message_byte_t;

    typedef struct packed {
        sym_t symbol;
        logic parity;
        logic last;
    } codeword_byte_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    pcnt_t       cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    reed_solomon_systematic_encoder_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // Predictor state: parity count, generator g1..gp, division remainder
    int             parity_now;
    sym_t           gen_coef  [MAX_PARITY];
    sym_t           remainder [MAX_PARITY];

    message_byte_t  pending_bytes [$];
    codeword_byte_t expected_bytes [$];
    message_byte_t  next_byte;
    codeword_byte_t want;

    int             errors          = 0;
    int             cycle_count     = 0;
    int             src_gap         = 0;
    int             sink_hold       = 0;
    bit             idle_on         = 1'b1;
    bit             long_hold_req   = 1'b0;
    bit             long_hold_taken = 1'b0;

    // GF(2^8) product, shift-and-add modulo the field polynomial
    function automatic sym_t gf_times(input sym_t a, input sym_t b);
        logic [SYM_W:0] x;
        sym_t           acc;
        x   = {1'b0, a};
        acc = '0;
        for (int k = 0; k < SYM_W; k++) begin
            if (b[k]) begin
                acc = acc ^ x[SYM_W-1:0];
            end
            x = x << 1;
            if (x[SYM_W]) begin
                x = x ^ FIELD_POLY;
            end
        end
        return acc;
    endfunction

    // Expand (x+a^0)(x+a^1)...(x+a^(p-1)); keep the non-leading coefficients
    function automatic void rebuild_generator(input int p);
        sym_t poly [0:MAX_PARITY];
        sym_t root;
        for (int i = 0; i <= MAX_PARITY; i++) begin
            poly[i] = '0;
        end
        poly[0] = 8'h01;
        root    = 8'h01;
        for (int i = 0; i < p; i++) begin
            for (int k = i + 1; k >= 1; k--) begin
                poly[k] = poly[k] ^ gf_times(root, poly[k-1]);
            end
            root = gf_times(root, 8'h02);
        end
        for (int i = 0; i < MAX_PARITY; i++) begin
            gen_coef[i] = (i < p) ? poly[i+1] : '0;
        end
    endfunction

    function automatic void clear_remainder();
        for (int j = 0; j < MAX_PARITY; j++) begin
            remainder[j] = '0;
        end
    endfunction

    // One accepted message byte: echo, divide, and on the last byte the parity
    function automatic void encode_symbol(input sym_t sym, input logic last);
        sym_t fb;
        fb = sym ^ remainder[0];
        expected_bytes.push_back('{sym, 1'b0, 1'b0});
        for (int j = 0; j + 1 < parity_now; j++) begin
            remainder[j] = remainder[j+1] ^ gf_times(gen_coef[j], fb);
        end
        remainder[parity_now-1] = gf_times(gen_coef[parity_now-1], fb);
        if (last) begin
            for (int j = 0; j < parity_now; j++) begin
                expected_bytes.push_back('{remainder[j], 1'b1, (j + 1 == parity_now)});
            end
            clear_remainder();
        end
    endfunction

    // Clock
    initial begin
        forever #6 aclk = ~aclk;
    end

    // Cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("reed_solomon_systematic_encoder_core_test: FAIL");
            $finish;
        end
    end

    // Driver: offers queued bytes, predicts on each accepted transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                encode_symbol(s_tdata, s_tlast);
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap != 0) begin
                    src_gap  <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    if (idle_on && $urandom_range(0, 7) == 0) begin
                        src_gap  <= $urandom_range(0, 8);
                        s_tvalid <= 1'b0;
                    end else begin
                        next_byte = pending_bytes.pop_front();
                        s_tvalid <= 1'b1;
                        s_tdata  <= next_byte.data;
                        s_tlast  <= next_byte.last;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each output transaction, then picks m_tready for the next cycle
    // reported fields: symbol/is_parity/last
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t: unexpected output: expected none, actual %02h/%b/%b",
                             $time, m_tdata, m_tuser[0], m_tlast);
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.symbol || m_tuser[0] !== want.parity ||
                        m_tlast !== want.last) begin
                        errors = errors + 1;
                        $display("%0t: mismatch: expected %02h/%b/%b, actual %02h/%b/%b",
                                 $time, want.symbol, want.parity, want.last,
                                 m_tdata, m_tuser[0], m_tlast);
                    end
                end
            end
            if (sink_hold != 0) begin
                sink_hold <= sink_hold - 1;
                m_tready  <= 1'b0;
            end else if (long_hold_req && !long_hold_taken) begin
                long_hold_taken <= 1'b1;
                sink_hold       <= LONG_HOLD - 1;
                m_tready        <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                sink_hold <= $urandom_range(0, 8);
                m_tready  <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic queue_byte(input sym_t data, input logic last);
        @(negedge aclk);
        pending_bytes.push_back('{data, last});
    endtask

    // A run of random bytes; the final one carries tlast when close is set
    task automatic queue_message(input int len, input bit close);
        @(negedge aclk);
        for (int i = 0; i < len; i++) begin
            pending_bytes.push_back('{sym_t'($urandom_range(0, 255)), close && (i == len - 1)});
        end
    endtask

    // Block idle: all bytes sent and every expected byte seen, then ready again
    task automatic settle();
        do @(posedge aclk);
        while (pending_bytes.size() != 0 || s_tvalid || expected_bytes.size() != 0);
        repeat (4) @(posedge aclk);
        do @(posedge aclk);
        while (!s_tready);
    endtask

    task automatic write_parity_count(input pcnt_t value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        // out-of-range counts are dropped and leave the remainder alone
        if (value >= 1 && value <= MAX_PARITY) begin
            parity_now = value;
            rebuild_generator(parity_now);
            clear_remainder();
        end
    endtask

    // Random messages, mostly short; sometimes left open for a mid-message write
    task automatic random_phase(input int budget, input int max_len);
        int sent;
        int len;
        sent = 0;
        while (sent < budget) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, max_len)
                                              : $urandom_range(1, 8);
            queue_message(len, 1'b1);
            sent = sent + len;
        end
        if ($urandom_range(0, 3) == 0) begin
            queue_message($urandom_range(1, 5), 1'b0);
        end
    endtask

    // Sequence: reset, directed cases, random phases, drain
    initial begin
        parity_now = PARITY_RESET;
        rebuild_generator(parity_now);
        clear_remainder();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset count, extreme bytes, single-byte message
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hff, 1'b1);
        queue_byte(8'h80, 1'b1);
        // smallest and largest parity counts
        write_parity_count(pcnt_t'(1));
        queue_byte(8'h01, 1'b0);
        queue_byte(8'haa, 1'b0);
        queue_byte(8'h55, 1'b1);
        write_parity_count(pcnt_t'(MAX_PARITY));
        queue_byte(8'hff, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h7f, 1'b1);
        // out-of-range counts are ignored
        write_parity_count(pcnt_t'(0));
        queue_byte(8'h12, 1'b1);
        write_parity_count(pcnt_t'(MAX_PARITY + 1));
        write_parity_count(pcnt_t'(63));
        queue_byte(8'hed, 1'b1);
        // valid write in the middle of a message restarts it
        write_parity_count(pcnt_t'(4));
        queue_byte(8'h11, 1'b0);
        queue_byte(8'h22, 1'b0);
        queue_byte(8'h33, 1'b0);
        write_parity_count(pcnt_t'(6));
        queue_byte(8'h44, 1'b0);
        queue_byte(8'h55, 1'b1);
        // ignored write in the middle of a message keeps the remainder
        queue_byte(8'hc3, 1'b0);
        queue_byte(8'h3c, 1'b0);
        write_parity_count(pcnt_t'(0));
        queue_byte(8'h5a, 1'b1);
        // all-zero message
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b1);

        write_parity_count(pcnt_t'(2));
        random_phase(50, 20);
        // long receiver stall while long messages keep coming
        write_parity_count(pcnt_t'(MAX_PARITY));
        @(negedge aclk);
        long_hold_req = 1'b1;
        random_phase(50, 40);
        write_parity_count(pcnt_t'($urandom_range(1, MAX_PARITY)));
        random_phase(50, 20);
        write_parity_count(pcnt_t'(1));
        random_phase(50, 20);
        write_parity_count(pcnt_t'($urandom_range(0, 63)));
        random_phase(50, 20);
        write_parity_count(pcnt_t'(17));
        random_phase(50, 20);
        // final stretch without idling on either side
        @(negedge aclk);
        idle_on = 1'b0;
        write_parity_count(pcnt_t'($urandom_range(1, MAX_PARITY)));
        random_phase(50, 20);
        write_parity_count(pcnt_t'(PARITY_RESET));
        random_phase(30, 20);

        settle();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (expected_bytes.size() != 0) begin
            errors = errors + 1;
            $display("%0t: %0d expected bytes never arrived", $time, expected_bytes.size());
        end
        if (errors == 0) begin
            $display("reed_solomon_systematic_encoder_core_test: PASS");
        end else begin
            $display("reed_solomon_systematic_encoder_core_test: FAIL");
        end
        $finish;
    end

endmodule
